>>> rtl/indexed_list_insert_delete_assert.svh
// ----------------------------------------------------------------------------
// indexed list assertion macros
// concurrent assertion helpers shared by the indexed list rtl
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_INSERT_DELETE_ASSERT_SVH
`define INDEXED_LIST_INSERT_DELETE_ASSERT_SVH

// assertion on an explicit clock and active-low reset
`define ILID_ASSERT_CR(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assertion on the block clock and reset
`define ILID_ASSERT(name, prop, msg) \
  `ILID_ASSERT_CR(name, clk_i, rst_ni, prop, msg)

`endif

>>> rtl/ilid_pkg.sv
// ----------------------------------------------------------------------------
// ilid_pkg
// shared types and constants of the indexed list
// ----------------------------------------------------------------------------
package ilid_pkg;

  localparam int unsigned DefCapacity = 16;
  localparam int unsigned ACT_W       = 3;
  localparam int unsigned POS_W       = 16;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned STAT_W      = 2;
  localparam int unsigned LEN_W       = 5;

  localparam logic signed [DATA_W-1:0] NOT_FOUND = -32'sd1;

  typedef enum logic [ACT_W-1:0] {
    ACT_GET  = 3'd0,
    ACT_HEAD = 3'd1,
    ACT_TAIL = 3'd2,
    ACT_AT   = 3'd3,
    ACT_DEL  = 3'd4
  } action_e;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE   = 2'd0,
    ST_ABSENT = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  typedef struct packed {
    logic ins;
    logic del;
  } ctrl_t;

endpackage

>>> rtl/ilid_cell.sv
// ----------------------------------------------------------------------------
// ilid_cell
// one storage cell of the list chain, shifts toward or away from the head
// ----------------------------------------------------------------------------
module ilid_cell #(
  parameter int unsigned IdxW  = 4,
  parameter int unsigned Index = 0
) (
  input  logic                                    clk_i,
  input  ilid_pkg::ctrl_t                         ctrl_i,
  input  logic               [IdxW-1:0]           pos_i,
  input  logic signed        [ilid_pkg::DATA_W-1:0] value_i,
  input  logic signed        [ilid_pkg::DATA_W-1:0] prev_i,
  input  logic signed        [ilid_pkg::DATA_W-1:0] next_i,
  output logic signed        [ilid_pkg::DATA_W-1:0] data_o,
  output logic                                    hit_o,
  output logic signed        [ilid_pkg::DATA_W-1:0] read_o
);

  localparam logic [IdxW-1:0] Me = IdxW'(Index);

  logic signed [ilid_pkg::DATA_W-1:0] data_q, data_d;
  logic at_pos, after_pos;

  assign at_pos    = (pos_i == Me);
  assign after_pos = (Me > pos_i);

  always_comb begin
    data_d = data_q;
    if (ctrl_i.ins) begin
      if (at_pos) begin
        data_d = value_i;
      end else if (after_pos) begin
        data_d = prev_i;
      end
    end else if (ctrl_i.del) begin
      if (at_pos || after_pos) begin
        data_d = next_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign hit_o  = at_pos;
  assign read_o = at_pos ? data_q : '0;

endmodule

>>> rtl/indexed_list_insert_delete.sv
// ----------------------------------------------------------------------------
// indexed_list_insert_delete
// ordered list of signed words with get, insert and delete by position
// result: registered, valid in the cycle after its input transfers
// throughput: one request per cycle while the output is not stalled, every cell shifts in the same cycle
// the output register frees in the cycle its result transfers
// reset: entry count and result valid clear, stored words stay undefined
// ----------------------------------------------------------------------------
module indexed_list_insert_delete #(
  parameter int unsigned CAPACITY = ilid_pkg::DefCapacity
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_ready_o,
  input  logic        [ilid_pkg::ACT_W-1:0]        action_i,
  input  logic signed [ilid_pkg::POS_W-1:0]        position_i,
  input  logic signed [ilid_pkg::DATA_W-1:0]       value_i,
  output logic                                     out_valid_o,
  input  logic                                     out_ready_i,
  output logic signed [ilid_pkg::DATA_W-1:0]       read_value_o,
  output logic        [ilid_pkg::STAT_W-1:0]       status_o,
  output logic        [ilid_pkg::LEN_W-1:0]        length_o
);

  `include "indexed_list_insert_delete_assert.svh"

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW = (CntW > ilid_pkg::POS_W - 1) ? CntW : ilid_pkg::POS_W - 1;

  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q;
  logic signed [ilid_pkg::DATA_W-1:0] rdval_q, rdval_d;
  ilid_pkg::status_e status_q, status_d;
  logic [ilid_pkg::LEN_W-1:0] length_q;

  logic signed [ilid_pkg::DATA_W-1:0] data_vec [CAPACITY];
  logic signed [ilid_pkg::DATA_W-1:0] prev_vec [CAPACITY];
  logic signed [ilid_pkg::DATA_W-1:0] next_vec [CAPACITY];
  logic signed [ilid_pkg::DATA_W-1:0] read_vec [CAPACITY];
  logic        [CAPACITY-1:0]         hit_vec;
  logic signed [ilid_pkg::DATA_W-1:0] read_or;

  ilid_pkg::ctrl_t op, cell_ctrl;
  logic [IdxW-1:0] cell_pos;
  logic            in_xfer;
  logic            pos_neg, pos_lt_cnt, pos_le_cnt, full;
  logic [CmpW-1:0] pos_mag, cnt_ext;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  assign pos_neg    = position_i[ilid_pkg::POS_W-1];
  assign pos_mag    = CmpW'(position_i[ilid_pkg::POS_W-2:0]);
  assign cnt_ext    = CmpW'(count_q);
  assign pos_lt_cnt = !pos_neg && (pos_mag < cnt_ext);
  assign pos_le_cnt = !pos_neg && (pos_mag <= cnt_ext);
  assign full       = (count_q == CntW'(CAPACITY));

  always_comb begin
    read_or = '0;
    for (int unsigned k = 0; k < CAPACITY; k++) begin
      read_or = read_or | read_vec[k];
    end
  end

  always_comb begin
    op       = '0;
    cell_pos = position_i[IdxW-1:0];
    status_d = ilid_pkg::ST_DONE;
    rdval_d  = '0;
    unique case (ilid_pkg::action_e'(action_i))
      ilid_pkg::ACT_GET: begin
        if (pos_lt_cnt) begin
          rdval_d = read_or;
        end else begin
          rdval_d  = ilid_pkg::NOT_FOUND;
          status_d = ilid_pkg::ST_ABSENT;
        end
      end
      ilid_pkg::ACT_HEAD: begin
        cell_pos = '0;
        if (full) status_d = ilid_pkg::ST_FULL;
        else      op.ins   = 1'b1;
      end
      ilid_pkg::ACT_TAIL: begin
        cell_pos = count_q[IdxW-1:0];
        if (full) status_d = ilid_pkg::ST_FULL;
        else      op.ins   = 1'b1;
      end
      ilid_pkg::ACT_AT: begin
        if (!pos_le_cnt) status_d = ilid_pkg::ST_ABSENT;
        else if (full)   status_d = ilid_pkg::ST_FULL;
        else             op.ins   = 1'b1;
      end
      ilid_pkg::ACT_DEL: begin
        if (!pos_lt_cnt) status_d = ilid_pkg::ST_ABSENT;
        else             op.del   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign cell_ctrl = in_xfer ? op : '0;

  always_comb begin
    count_d = count_q;
    if (cell_ctrl.ins) begin
      count_d = count_q + CntW'(1);
    end else if (cell_ctrl.del) begin
      count_d = count_q - CntW'(1);
    end
  end

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    if (k == 0) begin : g_first
      assign prev_vec[k] = '0;
    end else begin : g_mid_prev
      assign prev_vec[k] = data_vec[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign next_vec[k] = '0;
    end else begin : g_mid_next
      assign next_vec[k] = data_vec[k+1];
    end

    ilid_cell #(
      .IdxW  (IdxW),
      .Index (k)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (cell_ctrl),
      .pos_i   (cell_pos),
      .value_i (value_i),
      .prev_i  (prev_vec[k]),
      .next_i  (next_vec[k]),
      .data_o  (data_vec[k]),
      .hit_o   (hit_vec[k]),
      .read_o  (read_vec[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_xfer) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      rdval_q  <= rdval_d;
      status_q <= status_d;
      length_q <= ilid_pkg::LEN_W'(count_d);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = rdval_q;
  assign status_o     = status_q;
  assign length_o     = length_q;

  `ILID_ASSERT(a_ins_grows, cell_ctrl.ins |=> count_q == $past(count_q) + CntW'(1), "insert did not grow the list")
  `ILID_ASSERT(a_idle_holds, !in_xfer |=> $stable(count_q), "count changed without a transfer")
  `ILID_ASSERT(a_full_only_at_cap, (in_xfer && status_d == ilid_pkg::ST_FULL) |-> full, "full status below capacity")
  `ILID_ASSERT(a_one_hit, $onehot0(hit_vec), "more than one cell matched the position")

endmodule

>>> test/tb_indexed_list_insert_delete.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_indexed_list_insert_delete
// self-checking bench for the indexed list: a directed table of requests,
// then random request streams that grow, shrink and mix the list, checked
// against a shadow copy of the list with random input bursts, output stalls
// and one long output hold-off that backs up the input side
// ----------------------------------------------------------------------------
module tb_indexed_list_insert_delete;

  localparam int unsigned Capacity      = ilid_pkg::DefCapacity;
  localparam int unsigned RandomItems   = 450;
  localparam int unsigned PhaseLen      = 50;
  localparam int unsigned StallLimit    = 2000;
  localparam int unsigned HoldoffCycles = 64;
  localparam int unsigned DrainCycles   = 4;
  localparam int unsigned ReportLimit   = 10;

  localparam logic [ilid_pkg::ACT_W-1:0] ACT_RSVD5 = 3'd5;
  localparam logic [ilid_pkg::ACT_W-1:0] ACT_RSVD6 = 3'd6;
  localparam logic [ilid_pkg::ACT_W-1:0] ACT_RSVD7 = 3'd7;

  typedef enum int {PH_GROW, PH_SHRINK, PH_MIXED} phase_e;
  typedef enum int {RX_OPEN, RX_SPARSE, RX_COIN} rx_mode_e;

  typedef struct {
    logic        [ilid_pkg::ACT_W-1:0]  act;
    logic signed [ilid_pkg::POS_W-1:0]  pos;
    logic signed [ilid_pkg::DATA_W-1:0] val;
    bit                                 typed;
    logic signed [ilid_pkg::DATA_W-1:0] rd;
    ilid_pkg::status_e                  st;
    logic        [ilid_pkg::LEN_W-1:0]  len;
  } req_row_t;

  typedef struct {
    logic signed [ilid_pkg::DATA_W-1:0] rd;
    ilid_pkg::status_e                  st;
    logic        [ilid_pkg::LEN_W-1:0]  len;
  } list_result_t;

  logic                               clk_i;
  logic                               rst_ni       = 1'b0;
  logic                               in_valid_i   = 1'b0;
  logic                               in_ready_o;
  logic        [ilid_pkg::ACT_W-1:0]  action_i     = '0;
  logic signed [ilid_pkg::POS_W-1:0]  position_i   = '0;
  logic signed [ilid_pkg::DATA_W-1:0] value_i      = '0;
  logic                               out_valid_o;
  logic                               out_ready_i  = 1'b0;
  logic signed [ilid_pkg::DATA_W-1:0] read_value_o;
  logic        [ilid_pkg::STAT_W-1:0] status_o;
  logic        [ilid_pkg::LEN_W-1:0]  length_o;

  // typed expectation travelling with the offered request
  bit                                 cur_typed = 1'b0;
  logic signed [ilid_pkg::DATA_W-1:0] cur_rd    = '0;
  ilid_pkg::status_e                  cur_st    = ilid_pkg::ST_DONE;
  logic        [ilid_pkg::LEN_W-1:0]  cur_len   = '0;

  logic signed [ilid_pkg::DATA_W-1:0] model_words [Capacity];
  int unsigned                        model_len = 0;
  list_result_t                       awaited_results [$];

  int unsigned failures      = 0;
  int unsigned requests_sent = 0;
  int unsigned results_seen  = 0;
  int unsigned full_seen     = 0;
  int unsigned absent_seen   = 0;
  int unsigned peak_len      = 0;
  int unsigned burst_left    = 0;
  bit          holdoff_req   = 1'b0;
  bit          holdoff_done  = 1'b0;

  req_row_t directed_rows [25] = '{
    '{ilid_pkg::ACT_GET, 16'sd0, 32'sd0, 1'b1,
      ilid_pkg::NOT_FOUND, ilid_pkg::ST_ABSENT, 5'd0},
    '{ilid_pkg::ACT_DEL, 16'sd0, 32'sd0, 1'b1, 32'sd0, ilid_pkg::ST_ABSENT, 5'd0},
    '{ilid_pkg::ACT_AT, 16'sd1, 32'sd5, 1'b1, 32'sd0, ilid_pkg::ST_ABSENT, 5'd0},
    '{ilid_pkg::ACT_AT, 16'sh8000, 32'sd5, 1'b1, 32'sd0, ilid_pkg::ST_ABSENT, 5'd0},
    '{ilid_pkg::ACT_HEAD, 16'sh7FFF, 32'sh7FFFFFFF, 1'b1, 32'sd0, ilid_pkg::ST_DONE, 5'd1},
    '{ilid_pkg::ACT_TAIL, 16'sh8000, 32'sh80000000, 1'b1, 32'sd0, ilid_pkg::ST_DONE, 5'd2},
    '{ilid_pkg::ACT_AT, 16'sd1, 32'sd0, 1'b1, 32'sd0, ilid_pkg::ST_DONE, 5'd3},
    '{ilid_pkg::ACT_AT, 16'sd3, -32'sd1, 1'b1, 32'sd0, ilid_pkg::ST_DONE, 5'd4},
    '{ilid_pkg::ACT_AT, 16'sd5, 32'sd1, 1'b1, 32'sd0, ilid_pkg::ST_ABSENT, 5'd4},
    '{ilid_pkg::ACT_GET, 16'sd0, 32'shDEADBEEF, 1'b1,
      32'sh7FFFFFFF, ilid_pkg::ST_DONE, 5'd4},
    '{ilid_pkg::ACT_GET, 16'sd1, 32'sd0, 1'b1, 32'sd0, ilid_pkg::ST_DONE, 5'd4},
    '{ilid_pkg::ACT_GET, 16'sd2, 32'sd0, 1'b1, 32'sh80000000, ilid_pkg::ST_DONE, 5'd4},
    '{ilid_pkg::ACT_GET, 16'sd3, 32'sd0, 1'b1, -32'sd1, ilid_pkg::ST_DONE, 5'd4},
    '{ilid_pkg::ACT_GET, 16'sd4, 32'sd0, 1'b1,
      ilid_pkg::NOT_FOUND, ilid_pkg::ST_ABSENT, 5'd4},
    '{ilid_pkg::ACT_GET, 16'sh7FFF, 32'sd0, 1'b1,
      ilid_pkg::NOT_FOUND, ilid_pkg::ST_ABSENT, 5'd4},
    '{ilid_pkg::ACT_GET, -16'sd1, 32'sd0, 1'b1,
      ilid_pkg::NOT_FOUND, ilid_pkg::ST_ABSENT, 5'd4},
    '{ACT_RSVD5, 16'sd0, -32'sd1, 1'b1, 32'sd0, ilid_pkg::ST_DONE, 5'd4},
    '{ACT_RSVD6, 16'sh7FFF, 32'sh55555555, 1'b1, 32'sd0, ilid_pkg::ST_DONE, 5'd4},
    '{ACT_RSVD7, 16'sh8000, 32'shAAAAAAAA, 1'b1, 32'sd0, ilid_pkg::ST_DONE, 5'd4},
    '{ilid_pkg::ACT_DEL, 16'sd4, 32'sd0, 1'b1, 32'sd0, ilid_pkg::ST_ABSENT, 5'd4},
    '{ilid_pkg::ACT_DEL, 16'sh8000, 32'sd0, 1'b1, 32'sd0, ilid_pkg::ST_ABSENT, 5'd4},
    '{ilid_pkg::ACT_DEL, 16'sd0, 32'sd0, 1'b1, 32'sd0, ilid_pkg::ST_DONE, 5'd3},
    '{ilid_pkg::ACT_GET, 16'sd0, 32'sd0, 1'b0, 32'sd0, ilid_pkg::ST_DONE, 5'd0},
    '{ilid_pkg::ACT_DEL, 16'sd2, 32'sd0, 1'b0, 32'sd0, ilid_pkg::ST_DONE, 5'd0},
    '{ilid_pkg::ACT_HEAD, 16'sd9, 32'sh12345678, 1'b0, 32'sd0, ilid_pkg::ST_DONE, 5'd0}
  };

  indexed_list_insert_delete #(
    .CAPACITY(Capacity)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .position_i  (position_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .read_value_o(read_value_o),
    .status_o    (status_o),
    .length_o    (length_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic ilid_pkg::status_e insert_word(int pos,
                                                    logic signed [ilid_pkg::DATA_W-1:0] val);
    if (pos < 0 || pos > int'(model_len)) return ilid_pkg::ST_ABSENT;
    if (model_len >= Capacity) return ilid_pkg::ST_FULL;
    for (int k = int'(model_len); k > pos; k--) model_words[k] = model_words[k-1];
    model_words[pos] = val;
    model_len++;
    return ilid_pkg::ST_DONE;
  endfunction

  function automatic list_result_t apply_request(logic [ilid_pkg::ACT_W-1:0] act,
                                                 logic signed [ilid_pkg::POS_W-1:0] pos,
                                                 logic signed [ilid_pkg::DATA_W-1:0] val);
    list_result_t r;
    int           p;
    r.rd = '0;
    r.st = ilid_pkg::ST_DONE;
    p    = int'(pos);
    case (act)
      ilid_pkg::ACT_GET: begin
        if (p >= 0 && p < int'(model_len)) begin
          r.rd = model_words[p];
        end else begin
          r.rd = ilid_pkg::NOT_FOUND;
          r.st = ilid_pkg::ST_ABSENT;
        end
      end
      ilid_pkg::ACT_HEAD: r.st = insert_word(0, val);
      ilid_pkg::ACT_TAIL: r.st = insert_word(int'(model_len), val);
      ilid_pkg::ACT_AT:   r.st = insert_word(p, val);
      ilid_pkg::ACT_DEL: begin
        if (p >= 0 && p < int'(model_len)) begin
          for (int k = p; k + 1 < int'(model_len); k++) model_words[k] = model_words[k+1];
          model_len--;
        end else begin
          r.st = ilid_pkg::ST_ABSENT;
        end
      end
      default: ;
    endcase
    r.len = ilid_pkg::LEN_W'(model_len);
    return r;
  endfunction

  function automatic req_row_t random_request(phase_e ph);
    req_row_t row;
    int       th [5];
    int       pick;
    int       sel;
    case (ph)
      PH_GROW:   th = '{15, 40, 65, 90, 98};
      PH_SHRINK: th = '{20, 28, 36, 44, 98};
      default:   th = '{25, 40, 55, 75, 97};
    endcase
    pick = $urandom_range(0, 99);
    if (pick < th[0]) row.act = ilid_pkg::ACT_GET;
    else if (pick < th[1]) row.act = ilid_pkg::ACT_HEAD;
    else if (pick < th[2]) row.act = ilid_pkg::ACT_TAIL;
    else if (pick < th[3]) row.act = ilid_pkg::ACT_AT;
    else if (pick < th[4]) row.act = ilid_pkg::ACT_DEL;
    else row.act = ilid_pkg::ACT_W'($urandom_range(ACT_RSVD5, ACT_RSVD7));
    sel = $urandom_range(0, 9);
    if (sel < 8) row.pos = ilid_pkg::POS_W'($urandom_range(0, Capacity + 1));
    else if (sel == 8) row.pos = -ilid_pkg::POS_W'($urandom_range(1, 3));
    else row.pos = ilid_pkg::POS_W'($urandom);
    sel = $urandom_range(0, 19);
    case (sel)
      0:       row.val = 32'sh7FFFFFFF;
      1:       row.val = 32'sh80000000;
      2:       row.val = -32'sd1;
      default: row.val = $urandom;
    endcase
    row.typed = 1'b0;
    row.rd    = '0;
    row.st    = ilid_pkg::ST_DONE;
    row.len   = '0;
    return row;
  endfunction

  task automatic flag_failure(string msg);
    failures++;
    if (failures <= ReportLimit) $display("%0t ns: %s", $realtime, msg);
  endtask

  task automatic offer(req_row_t row);
    in_valid_i <= 1'b1;
    action_i   <= row.act;
    position_i <= row.pos;
    value_i    <= row.val;
    cur_typed  <= row.typed;
    cur_rd     <= row.rd;
    cur_st     <= row.st;
    cur_len    <= row.len;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // sender runs in bursts, a gap between some bursts drops valid
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // result check first, then predict the request accepted at this edge
  always @(posedge clk_i) begin
    list_result_t want;
    list_result_t pred;
    if (out_valid_o && out_ready_i) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        flag_failure($sformatf("result with nothing awaited: rd=%h st=%0d len=%0d",
                               read_value_o, status_o, length_o));
      end else begin
        want = awaited_results.pop_front();
        if (read_value_o !== want.rd || status_o !== want.st || length_o !== want.len) begin
          flag_failure($sformatf({"mismatch: expected rd=%h st=%0d len=%0d,",
                                  " got rd=%h st=%0d len=%0d"},
                                 want.rd, want.st, want.len,
                                 read_value_o, status_o, length_o));
        end
      end
    end
    if (in_valid_i && in_ready_o) begin
      pred = apply_request(action_i, position_i, value_i);
      if (cur_typed) begin
        pred.rd  = cur_rd;
        pred.st  = cur_st;
        pred.len = cur_len;
      end
      awaited_results.push_back(pred);
      requests_sent++;
      if (pred.st == ilid_pkg::ST_FULL) full_seen++;
      if (pred.st == ilid_pkg::ST_ABSENT) absent_seen++;
      if (model_len > peak_len) peak_len = model_len;
    end
  end

  // receiver stall pattern plus one long hold-off on request
  initial begin
    int       stretch;
    rx_mode_e mode;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (holdoff_req && !holdoff_done) begin
        out_ready_i <= 1'b0;
        repeat (HoldoffCycles) @(posedge clk_i);
        holdoff_done = 1'b1;
      end
      stretch = $urandom_range(4, 40);
      mode    = rx_mode_e'($urandom_range(RX_OPEN, RX_COIN));
      repeat (stretch) begin
        case (mode)
          RX_OPEN:   out_ready_i <= 1'b1;
          RX_SPARSE: out_ready_i <= ($urandom_range(0, 2) == 0);
          default:   out_ready_i <= $urandom_range(0, 1);
        endcase
        @(posedge clk_i);
      end
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("timeout: no transfer for %0d cycles", StallLimit);
    $display("tb_indexed_list_insert_delete NOT OK");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed_rows[n]) begin
      offer(directed_rows[n]);
      pace();
    end
    for (int i = 0; i < RandomItems; i++) begin
      if (i == RandomItems / 3) holdoff_req <= 1'b1;
      offer(random_request(phase_e'((i / PhaseLen) % 3)));
      pace();
    end
    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("covered %0d requests and %0d results, peak length %0d of %0d",
             requests_sent, results_seen, peak_len, Capacity);
    $display("full-store drops %0d, absent positions %0d, failures %0d",
             full_seen, absent_seen, failures);
    if (failures == 0 && awaited_results.size() == 0) begin
      $display("tb_indexed_list_insert_delete OK");
    end else begin
      $display("tb_indexed_list_insert_delete NOT OK");
    end
    $finish;
  end

endmodule
